// ===== rtl/blr_pkg.sv =====
// Shared types and constants for the Bresenham line rasterizer.
package blr_pkg;

   localparam int COORD_BITS = 6;
   localparam int COLOR_BITS = 8;
   // Error term spans (-d, 3d] for d below 2**COORD_BITS.
   localparam int ERR_BITS   = COORD_BITS + 3;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   typedef struct packed {
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
      color_type red_in;
      color_type green_in;
      color_type blue_in;
      color_type alpha_in;
   } req_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      color_type red_out;
      color_type green_out;
      color_type blue_out;
      color_type alpha_out;
      logic      last_pixel;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN
   } blr_state_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last;
   } dp_status_type;

endpackage

// ===== rtl/bresenham_line_rasterizer_top.sv =====
// Top level of the Bresenham line rasterizer: controller plus datapath.
// The first pixel item is on the ports once the setup state has registered the line.
// A line passes through an accept state, then a setup state for axis swap,
//   ordering and deltas, then gives one pixel per cycle from the stepping
//   loop in the datapath until the last pixel of its major extent.
// Reset clears only the state machine; results cannot be stalled.
// start is taken only while busy is low; busy drops after the last pixel.
module bresenham_line_rasterizer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  blr_pkg::req_type req_item,
   output logic             busy,
   output logic             rsp_valid,
   output blr_pkg::rsp_type rsp_item
);
   import blr_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // state machine: idle, setup, run
   blr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // per-line registers and error stepping
   blr_dp u_dp (
      .clock    (clock),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

   // Pixels only come out while a line is in progress.
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("pixel strobe while idle");

   // The last pixel ends the line; the block is free in the next cycle.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last_pixel |=> !busy && !rsp_valid)
      else $error("block still busy after last pixel");

   // Pixels of one line come out back to back until the last one.
   a_run_contig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last_pixel |=> rsp_valid)
      else $error("gap inside a line");

   // An accepted item passes through the setup state before its first pixel.
   a_setup_gap: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("pixel without setup cycle");

endmodule

// ===== rtl/blr_ctrl.sv =====
// Sequencing state machine for the line rasterizer.
module blr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  blr_pkg::dp_status_type status,
   output blr_pkg::ctrl_cmd_type cmd,
   output logic                  busy,
   output logic                  rsp_valid
);
   import blr_pkg::*;

   blr_state_type state_ff;
   blr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         ST_RUN: begin
            cmd.step  = 1'b1;
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/blr_dp.sv =====
// Datapath: axis swap, endpoint ordering and Bresenham error stepping.
module blr_dp (
   input  logic                  clock,
   input  blr_pkg::req_type      req_item,
   input  blr_pkg::ctrl_cmd_type cmd,
   output blr_pkg::dp_status_type status,
   output blr_pkg::rsp_type      rsp_item
);
   import blr_pkg::*;

   req_type                  req_ff;
   logic                     steep_ff, steep_in;
   logic                     up_ff, up_in;
   coord_type                major_ff, major_in;
   coord_type                minor_ff, minor_in;
   coord_type                end_ff, end_in;
   coord_type                d_ff, d_in;
   logic [COORD_BITS:0]      inc_ff, inc_in;
   logic signed [ERR_BITS-1:0] err_ff, err_in;

   // setup terms
   logic signed [COORD_BITS:0] dx, dy, neg_dx, neg_dy;
   coord_type adx, ady, a_maj, a_min, b_maj, b_min;
   coord_type s_maj, s_min, e_maj, e_min, adm;
   logic      steep, swap_ends, up;

   // stepping terms
   logic signed [ERR_BITS-1:0] err_sum, d_ext, d_twice;
   logic                       over;

   always_comb begin
      dx     = $signed({1'b0, req_ff.x_end}) - $signed({1'b0, req_ff.x_start});
      dy     = $signed({1'b0, req_ff.y_end}) - $signed({1'b0, req_ff.y_start});
      neg_dx = -dx;
      neg_dy = -dy;
      adx    = dx[COORD_BITS] ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
      ady    = dy[COORD_BITS] ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
      steep  = adx < ady;

      a_maj = steep ? req_ff.y_start : req_ff.x_start;
      a_min = steep ? req_ff.x_start : req_ff.y_start;
      b_maj = steep ? req_ff.y_end   : req_ff.x_end;
      b_min = steep ? req_ff.x_end   : req_ff.y_end;

      swap_ends = a_maj > b_maj;
      s_maj = swap_ends ? b_maj : a_maj;
      s_min = swap_ends ? b_min : a_min;
      e_maj = swap_ends ? a_maj : b_maj;
      e_min = swap_ends ? a_min : b_min;

      up  = e_min > s_min;
      adm = up ? (e_min - s_min) : (s_min - e_min);
   end

   always_comb begin
      d_ext   = $signed({3'b000, d_ff});
      d_twice = $signed({2'b00, d_ff, 1'b0});
      err_sum = err_ff + $signed({2'b00, inc_ff});
      over    = err_sum > d_ext;
   end

   always_comb begin
      steep_in = steep_ff;
      up_in    = up_ff;
      major_in = major_ff;
      minor_in = minor_ff;
      end_in   = end_ff;
      d_in     = d_ff;
      inc_in   = inc_ff;
      err_in   = err_ff;
      if (cmd.setup) begin
         steep_in = steep;
         up_in    = up;
         major_in = s_maj;
         minor_in = s_min;
         end_in   = e_maj;
         d_in     = e_maj - s_maj;
         inc_in   = {adm, 1'b0};
         err_in   = '0;
      end else if (cmd.step) begin
         major_in = major_ff + coord_type'(1);
         if (over) begin
            minor_in = up_ff ? (minor_ff + coord_type'(1)) : (minor_ff - coord_type'(1));
            err_in   = err_sum - d_twice;
         end else begin
            err_in = err_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
      steep_ff <= steep_in;
      up_ff    <= up_in;
      major_ff <= major_in;
      minor_ff <= minor_in;
      end_ff   <= end_in;
      d_ff     <= d_in;
      inc_ff   <= inc_in;
      err_ff   <= err_in;
   end

   assign status.last = major_ff == end_ff;

   always_comb begin
      rsp_item.pixel_x    = steep_ff ? minor_ff : major_ff;
      rsp_item.pixel_y    = steep_ff ? major_ff : minor_ff;
      rsp_item.red_out    = req_ff.red_in;
      rsp_item.green_out  = req_ff.green_in;
      rsp_item.blue_out   = req_ff.blue_in;
      rsp_item.alpha_out  = req_ff.alpha_in;
      rsp_item.last_pixel = status.last;
   end

endmodule

// ===== tb/sv/line_pixel_checker.sv =====
// Checker for the line rasterizer: predicts each line's pixel items and compares them.
module line_pixel_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  blr_pkg::req_type req_item,
   input  logic             rsp_valid,
   input  blr_pkg::rsp_type rsp_item,
   output int               mismatches,
   output int               pending_pixels,
   output int               lines_seen,
   output int               pixels_checked
);
   import blr_pkg::*;

   localparam int REPORT_LIMIT = 10;

   rsp_type expected_pixels[$];
   rsp_type want;
   int      error_count = 0;
   int      line_count  = 0;
   int      pixel_count = 0;

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // Walk the major axis from the low end, stepping the minor axis on error overflow.
   function automatic void rasterize(input req_type line);
      int      major_lo, minor_lo, major_hi, minor_hi, swap_tmp;
      int      extent, rise, err, minor_pos, minor_dir;
      bit      steep;
      rsp_type pix;
      major_lo = int'(line.x_start);
      minor_lo = int'(line.y_start);
      major_hi = int'(line.x_end);
      minor_hi = int'(line.y_end);
      steep = magnitude(major_hi - major_lo) < magnitude(minor_hi - minor_lo);
      if (steep) begin
         swap_tmp = major_lo; major_lo = minor_lo; minor_lo = swap_tmp;
         swap_tmp = major_hi; major_hi = minor_hi; minor_hi = swap_tmp;
      end
      if (major_lo > major_hi) begin
         swap_tmp = major_lo; major_lo = major_hi; major_hi = swap_tmp;
         swap_tmp = minor_lo; minor_lo = minor_hi; minor_hi = swap_tmp;
      end
      extent    = major_hi - major_lo;
      rise      = 2 * magnitude(minor_hi - minor_lo);
      err       = 0;
      minor_pos = minor_lo;
      minor_dir = (minor_hi > minor_lo) ? 1 : -1;
      for (int major_pos = major_lo; major_pos <= major_hi; major_pos++) begin
         pix.pixel_x    = coord_type'(steep ? minor_pos : major_pos);
         pix.pixel_y    = coord_type'(steep ? major_pos : minor_pos);
         pix.red_out    = line.red_in;
         pix.green_out  = line.green_in;
         pix.blue_out   = line.blue_in;
         pix.alpha_out  = line.alpha_in;
         pix.last_pixel = (major_pos == major_hi);
         expected_pixels.push_back(pix);
         err += rise;
         if (err > extent) begin
            minor_pos += minor_dir;
            err       -= 2 * extent;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t unexpected pixel item x=%0d y=%0d last=%b", $realtime,
                           rsp_item.pixel_x, rsp_item.pixel_y, rsp_item.last_pixel);
            end else begin
               want = expected_pixels.pop_front();
               pixel_count++;
               if (rsp_item.pixel_x    !== want.pixel_x    ||
                   rsp_item.pixel_y    !== want.pixel_y    ||
                   rsp_item.red_out    !== want.red_out    ||
                   rsp_item.green_out  !== want.green_out  ||
                   rsp_item.blue_out   !== want.blue_out   ||
                   rsp_item.alpha_out  !== want.alpha_out  ||
                   rsp_item.last_pixel !== want.last_pixel) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("%0t pixel mismatch: got x=%0d y=%0d rgba=%h last=%b",
                              $realtime, rsp_item.pixel_x, rsp_item.pixel_y,
                              {rsp_item.red_out, rsp_item.green_out,
                               rsp_item.blue_out, rsp_item.alpha_out},
                              rsp_item.last_pixel);
                     $display("   want x=%0d y=%0d rgba=%h last=%b",
                              want.pixel_x, want.pixel_y,
                              {want.red_out, want.green_out, want.blue_out, want.alpha_out},
                              want.last_pixel);
                  end
               end
            end
         end
         if (start && !busy) begin
            rasterize(req_item);
            line_count++;
         end
      end
      mismatches     <= error_count;
      pending_pixels <= expected_pixels.size();
      lines_seen     <= line_count;
      pixels_checked <= pixel_count;
   end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the line rasterizer testbench: clock, reset, line stimulus and verdict.
module testbench;
   import blr_pkg::*;

   localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
   localparam int RANDOM_LINES = 500;
   // Worst case is roughly 520 lines, each at its longest and followed by the longest idle gap.
   localparam int CYCLE_LIMIT  = 400000;
   // Extra cycles after the last expected pixel to catch stray items.
   localparam int DRAIN_CYCLES = 8;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   int mismatches;
   int pending_pixels;
   int lines_seen;
   int pixels_checked;
   int cycle_count = 0;

   always #5 clock = ~clock;

   bresenham_line_rasterizer_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Predicts and compares every pixel item; we only feed lines and judge.
   line_pixel_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item),
      .mismatches     (mismatches),
      .pending_pixels (pending_pixels),
      .lines_seen     (lines_seen),
      .pixels_checked (pixels_checked)
   );

   // Watchdog: a hung handshake or a lost pixel ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels still expected",
                  cycle_count, pending_pixels);
         $display("bresenham_line_rasterizer_top test failed");
         $finish;
      end
   end

   function automatic coord_type clamp_coord(input int v);
      if (v < 0) return coord_type'(0);
      if (v > COORD_MAX) return coord_type'(COORD_MAX);
      return coord_type'(v);
   endfunction

   function automatic req_type make_line(input int x0, input int y0, input int x1,
                                         input int y1, input logic [31:0] rgba);
      req_type line;
      line.x_start  = clamp_coord(x0);
      line.y_start  = clamp_coord(y0);
      line.x_end    = clamp_coord(x1);
      line.y_end    = clamp_coord(y1);
      line.red_in   = rgba[31:24];
      line.green_in = rgba[23:16];
      line.blue_in  = rgba[15:8];
      line.alpha_in = rgba[7:0];
      return line;
   endfunction

   // Random line mix: mostly arbitrary endpoints, plus short lines, axis-aligned
   // and 45-degree lines, single points, and endpoints pinned to the canvas edges.
   function automatic req_type random_line();
      int kind, x0, y0, x1, y1, len;
      kind = $urandom_range(0, 99);
      x0 = $urandom_range(0, COORD_MAX);
      y0 = $urandom_range(0, COORD_MAX);
      x1 = $urandom_range(0, COORD_MAX);
      y1 = $urandom_range(0, COORD_MAX);
      if (kind >= 50 && kind < 70) begin
         // short line around a random anchor, clipped at the edges
         x1 = x0 + $urandom_range(0, 12) - 6;
         y1 = y0 + $urandom_range(0, 12) - 6;
      end else if (kind >= 70 && kind < 80) begin
         len = $urandom_range(0, COORD_MAX);
         case ($urandom_range(0, 2))
            0: y1 = y0;                        // horizontal
            1: x1 = x0;                        // vertical
            default: begin                     // equal extents
               x1 = (x0 + len > COORD_MAX) ? x0 - len : x0 + len;
               y1 = (y0 + len > COORD_MAX) ? y0 - len : y0 + len;
               if (x1 < 0) x1 = 0;
               if (y1 < 0) y1 = 0;
               if (x1 - x0 != y1 - y0 && x0 - x1 != y1 - y0 && x1 - x0 != y0 - y1) begin
                  len = (x0 > x1 ? x0 - x1 : x1 - x0);
                  y1  = (y0 + len > COORD_MAX) ? y0 - len : y0 + len;
               end
            end
         endcase
      end else if (kind >= 80 && kind < 90) begin
         x1 = x0;                              // single point
         y1 = y0;
      end else if (kind >= 90) begin
         x0 = $urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 1) : $urandom_range(0, 1);
         y0 = $urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 1) : $urandom_range(0, 1);
         x1 = $urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 1) : $urandom_range(0, 1);
         y1 = $urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 1) : $urandom_range(0, 1);
      end
      return make_line(x0, y0, x1, y1, $urandom());
   endfunction

   // Idle length between lines: mostly back to back or short, sometimes long.
   function automatic int pick_gap(input bit back_to_back);
      int roll;
      if (back_to_back) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Present one line and hold it until the block takes it (start high, busy low).
   // start is left high so a back-to-back line needs no second assignment.
   task automatic drive_line(input req_type line);
      start    <= 1'b1;
      req_item <= line;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   initial begin
      req_type directed_lines[$];

      // Directed lines: single points at both canvas corners, full-length
      // horizontal, vertical and diagonal lines in both directions (diagonals
      // have equal extents and must not be treated as steep), shallow and
      // steep lines with both slope signs and reversed endpoints, and the
      // shortest two-pixel cases. Colors sweep all-zero, all-one and
      // alternating bit patterns.
      directed_lines.push_back(make_line( 0,  0,  0,  0, 32'h0000_0000));
      directed_lines.push_back(make_line(63, 63, 63, 63, 32'hFFFF_FFFF));
      directed_lines.push_back(make_line( 0,  0, 63,  0, 32'hAA55_AA55));
      directed_lines.push_back(make_line(63,  0,  0,  0, 32'h55AA_55AA));
      directed_lines.push_back(make_line( 0,  0,  0, 63, 32'hFF00_FF00));
      directed_lines.push_back(make_line( 0, 63,  0,  0, 32'h00FF_00FF));
      directed_lines.push_back(make_line( 0,  0, 63, 63, 32'h0123_4567));
      directed_lines.push_back(make_line(63,  0,  0, 63, 32'h89AB_CDEF));
      directed_lines.push_back(make_line( 0, 63, 63,  0, 32'hFEDC_BA98));
      directed_lines.push_back(make_line(63, 63,  0,  0, 32'h7654_3210));
      directed_lines.push_back(make_line(10,  5, 20,  9, 32'h8000_0001));
      directed_lines.push_back(make_line(20,  9, 10,  5, 32'h0180_0180));
      directed_lines.push_back(make_line( 5, 10,  9, 40, 32'hF0F0_0F0F));
      directed_lines.push_back(make_line( 9, 40,  5, 10, 32'h0F0F_F0F0));
      directed_lines.push_back(make_line(30,  2, 25, 60, 32'hCCCC_3333));
      directed_lines.push_back(make_line( 2, 30, 60, 25, 32'h3333_CCCC));
      directed_lines.push_back(make_line( 0,  0,  1,  0, 32'h1111_2222));
      directed_lines.push_back(make_line( 0,  0,  1,  1, 32'h4444_8888));
      directed_lines.push_back(make_line( 1,  0,  0,  1, 32'h7777_EEEE));
      directed_lines.push_back(make_line( 0,  0,  0,  1, 32'hDEAD_BEEF));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_lines[i]) begin
         drive_line(directed_lines[i]);
         idle_for(pick_gap(1'b0));
      end

      // Every third block of 40 lines runs back to back with no idling.
      for (int i = 0; i < RANDOM_LINES; i++) begin
         drive_line(random_line());
         idle_for(pick_gap(((i / 40) % 3) == 1));
      end
      start <= 1'b0;

      // Drain: wait for the last predicted pixel, then watch for stray items.
      do @(posedge clock); while (pending_pixels != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Rasterized %0d lines (%0d directed, %0d random) in %0d cycles",
               lines_seen, directed_lines.size(), RANDOM_LINES, cycle_count);
      $display("Compared %0d pixel items field by field, %0d mismatches",
               pixels_checked, mismatches);
      if (mismatches == 0 && pending_pixels == 0) begin
         $display("bresenham_line_rasterizer_top test passed");
      end else begin
         $display("bresenham_line_rasterizer_top test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/blr_pkg.sv
rtl/blr_ctrl.sv
rtl/blr_dp.sv
rtl/bresenham_line_rasterizer_top.sv
tb/sv/line_pixel_checker.sv
tb/sv/testbench.sv
